// File: hw/rtl/mdts_pkg.sv
// Shared types and constants of the minimum-delay task scheduler.
// Holds the slot record, the broadcast command of the cell chain and the codes.
// Depends on nothing; every other file of the block imports it.
package mdts_pkg;

    localparam int DATA_W            = 32;
    localparam int PEND_W            = 8;
    localparam int ID_W              = 5;
    localparam int SLOT_W            = 6;   // covers every slot of the largest table
    localparam int DEFAULT_MAX_TASKS = 32;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;

    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};

    // One table slot.
    typedef struct packed {
        logic [DATA_W-1:0] delay;
        logic [DATA_W-1:0] period;
        logic [PEND_W-1:0] pend;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_NONE  = 3'd0,
        CELL_ADD   = 3'd1,
        CELL_SHIFT = 3'd2,
        CELL_TICK  = 3'd3,
        CELL_DISP  = 3'd4
    } cell_op_t;

    // Command seen by every cell of the chain in the same cycle.
    typedef struct packed {
        cell_op_t          op;
        logic [SLOT_W-1:0] pos;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] period;
        logic [ID_W-1:0]   id;
    } cell_ctl_t;

endpackage

// File: hw/rtl/mdts_cell.sv
// One slot of the task table, a link in the cell chain.
// Takes the broadcast command and its upper neighbor's record; uses mdts_pkg.
module mdts_cell #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  mdts_pkg::cell_ctl_t ctl,
    input  mdts_pkg::entry_t    nbr,
    output mdts_pkg::entry_t    q
);
    import mdts_pkg::*;

    entry_t q_reg;
    entry_t q_next;
    logic   hit;

    assign hit = (ctl.pos == SLOT_W'(IDX));

    always_comb
    begin
        q_next = q_reg;
        unique case (ctl.op)
            CELL_ADD:
            begin
                if (hit)
                begin
                    q_next.delay  = ctl.value;
                    q_next.period = ctl.period;
                    q_next.pend   = '0;
                    q_next.id     = ctl.id;
                end
            end
            CELL_SHIFT:
            begin
                // Slots at and above the removed one move down by one.
                if (SLOT_W'(IDX) >= ctl.pos)
                    q_next = nbr;
            end
            CELL_TICK:
            begin
                if (hit)
                begin
                    if (q_reg.delay != '0)
                        q_next.delay = q_reg.delay - DATA_W'(1);
                    else
                    begin
                        q_next.delay = q_reg.period;
                        if (q_reg.pend != PEND_MAX)
                            q_next.pend = q_reg.pend + PEND_W'(1);
                    end
                end
            end
            CELL_DISP:
            begin
                if (hit)
                    q_next.pend = q_reg.pend - PEND_W'(1);
                else
                    q_next.delay = q_reg.delay - ctl.value;
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// File: hw/rtl/min_delay_task_scheduler.sv
// Top level of the minimum-delay task scheduler: sequencer, search and output stage.
// Instantiates a chain of mdts_cell; uses mdts_pkg.
//
// Usage: one operation arrives per transfer on the s_ channel. s_tuser carries the
// opcode (add, delete, tick, dispatch); s_tdata carries start delay, period and slot.
// Every operation gives exactly one result transfer on the m_ channel: m_tuser holds
// status and the run flag, m_tdata the task id and the number of tasks held.
// The table lives in a row of cells, one per slot; a delete or a one-shot removal
// shifts every higher cell down by one at once, and a dispatch subtracts the
// recorded least delay in every other cell at once.
// Flow: a rejected add or delete, a tick and an idle dispatch go straight to the
// result register. Add, delete and a running dispatch first rescan the table for
// the least delay, one slot per cycle over the N tasks held (a one-shot dispatch
// removes its slot before the scan). One operation is in work at a time and
// s_tready is high only between operations. Reset empties the table; slot
// contents are not cleared and are never read before they are written. When the
// receiver stalls, the result waits in the output register; the next operation is
// taken, but its own result waits for the register.
module min_delay_task_scheduler #(
    parameter int MAX_TASKS = mdts_pkg::DEFAULT_MAX_TASKS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // start_delay[31:0], repeat_period[63:32], slot[68:64]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // task_id[4:0], tasks_held[10:5]
    output logic [2:0]  m_tuser    // status[1:0], run_valid[2]
);
    import mdts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_REMOVE = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  least_slot_reg, least_slot_next;
    logic [DATA_W-1:0] least_delay_reg, least_delay_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [IDX_W-1:0]  best_slot_reg, best_slot_next;
    logic [DATA_W-1:0] best_delay_reg, best_delay_next;
    logic [IDX_W-1:0]  run_slot_reg, run_slot_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_run_reg, res_run_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;
    logic [2:0]        m_tuser_reg, m_tuser_next;

    entry_t            cells [MAX_TASKS];
    cell_ctl_t         ctl;
    entry_t            least_e;
    logic [DATA_W-1:0] scan_delay;

    logic [1:0]        opcode;
    logic [DATA_W-1:0] start_delay;
    logic [DATA_W-1:0] repeat_period;
    logic [4:0]        slot;
    logic              accept;
    logic              out_free;

    assign opcode        = s_tuser[1:0];
    assign start_delay   = s_tdata[31:0];
    assign repeat_period = s_tdata[63:32];
    assign slot          = s_tdata[68:64];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign least_e    = cells[least_slot_reg];
    assign scan_delay = cells[scan_reg[IDX_W-1:0]].delay;

    // The chain of slot cells; the top cell shifts in its own record.
    for (genvar k = 0; k < MAX_TASKS; k++)
    begin : g_cell
        entry_t nbr;
        if (k + 1 < MAX_TASKS)
        begin : g_mid
            assign nbr = cells[k+1];
        end
        else
        begin : g_top
            assign nbr = cells[k];
        end
        mdts_cell #(.IDX(k)) u_cell (
            .clk (clk),
            .ctl (ctl),
            .nbr (nbr),
            .q   (cells[k])
        );
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        least_slot_next  = least_slot_reg;
        least_delay_next = least_delay_reg;
        scan_next        = scan_reg;
        best_slot_next   = best_slot_reg;
        best_delay_next  = best_delay_reg;
        run_slot_next    = run_slot_reg;
        res_status_next  = res_status_reg;
        res_run_next     = res_run_reg;
        res_id_next      = res_id_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        ctl        = '0;
        ctl.op     = CELL_NONE;
        ctl.value  = start_delay;
        ctl.period = repeat_period;
        ctl.id     = ID_W'(count_reg);

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_run_next    = 1'b0;
                    res_id_next     = '0;
                    scan_next       = '0;
                    state_next      = S_DONE;
                    unique case (opcode)
                        OP_ADD:
                        begin
                            if (count_reg == CNT_W'(MAX_TASKS))
                                res_status_next = ST_FULL;
                            else
                            begin
                                ctl.op      = CELL_ADD;
                                ctl.pos     = SLOT_W'(count_reg);
                                res_id_next = ID_W'(count_reg);
                                count_next  = count_reg + CNT_W'(1);
                                state_next  = S_SEARCH;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (7'(slot) >= 7'(count_reg))
                                res_status_next = ST_BAD_SLOT;
                            else
                            begin
                                ctl.op     = CELL_SHIFT;
                                ctl.pos    = SLOT_W'(slot);
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_SEARCH;
                            end
                        end
                        OP_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                ctl.op  = CELL_TICK;
                                ctl.pos = SLOT_W'(least_slot_reg);
                            end
                        end
                        OP_DISPATCH:
                        begin
                            if (count_reg != '0 && least_e.pend != '0)
                            begin
                                // Every other slot loses the recorded least delay,
                                // the chosen slot loses one pending run.
                                ctl.op        = CELL_DISP;
                                ctl.pos       = SLOT_W'(least_slot_reg);
                                ctl.value     = least_delay_reg;
                                res_run_next  = 1'b1;
                                res_id_next   = least_e.id;
                                run_slot_next = least_slot_reg;
                                if (least_e.period == '0)
                                    state_next = S_REMOVE;
                                else
                                    state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_REMOVE:
            begin
                // A one-shot task leaves the table after its run.
                ctl.op     = CELL_SHIFT;
                ctl.pos    = SLOT_W'(run_slot_reg);
                count_next = count_reg - CNT_W'(1);
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (scan_reg >= count_reg)
                begin
                    if (count_reg == '0)
                    begin
                        least_slot_next  = '0;
                        least_delay_next = '0;
                    end
                    else
                    begin
                        least_slot_next  = best_slot_reg;
                        least_delay_next = best_delay_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    // Strict compare keeps the lowest slot among equal delays.
                    if (scan_reg == '0 || scan_delay < best_delay_reg)
                    begin
                        best_slot_next  = scan_reg[IDX_W-1:0];
                        best_delay_next = scan_delay;
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, 6'(count_reg), res_id_reg};
                    m_tuser_next  = {res_run_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            least_slot_reg  <= '0;
            least_delay_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            least_slot_reg  <= least_slot_next;
            least_delay_reg <= least_delay_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        best_slot_reg  <= best_slot_next;
        best_delay_reg <= best_delay_next;
        run_slot_reg   <= run_slot_next;
        res_status_reg <= res_status_next;
        res_run_reg    <= res_run_next;
        res_id_reg     <= res_id_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: hw/rtl/mdts_checker.sv
// Port-level checks of the minimum-delay task scheduler, bound to its top level.
// Sees only the top-level ports; uses mdts_pkg for the status codes.
module mdts_checker #(
    parameter int MAX_TASKS = mdts_pkg::DEFAULT_MAX_TASKS
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import mdts_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
        else $error("run reported with an error status");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == ST_FULL |-> m_tdata[10:5] == 6'(MAX_TASKS))
        else $error("table full reported below capacity");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken before the first was done");

endmodule

bind min_delay_task_scheduler mdts_checker #(.MAX_TASKS(MAX_TASKS)) u_mdts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/testbench.sv
// Self-checking testbench for min_delay_task_scheduler.
// Drives random and directed operations on the stream input, predicts every result
// with a behavioral table model, and checks each output transfer. Uses mdts_pkg.
`timescale 1ns / 100ps

module testbench;
    import mdts_pkg::*;

    localparam int NTASK    = 32;
    localparam int WD_LIMIT = 20000;

    // One expected result: status, run flag, task id and table occupancy.
    typedef struct packed {
        logic [1:0] status;
        logic       run;
        logic [4:0] id;
        logic [5:0] held;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    min_delay_task_scheduler #(.MAX_TASKS(NTASK)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Shadow copy of the task table, kept in step with every accepted operation.
    logic [31:0] sh_delay [NTASK];
    logic [31:0] sh_period[NTASK];
    logic [7:0]  sh_pend  [NTASK];
    logic [4:0]  sh_id    [NTASK];
    int          sh_count;
    int          sh_least;
    logic [31:0] sh_least_delay;

    result_t expected_results[$];
    int      error_count;
    int      idle_cycles;
    bit      idle_enable;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Find the task with the least delay; the lowest slot wins a tie.
    function automatic void find_least();
        sh_least       = 0;
        sh_least_delay = '0;
        if (sh_count == 0)
            return;
        sh_least_delay = sh_delay[0];
        for (int k = 1; k < sh_count; k++)
        begin
            if (sh_delay[k] < sh_least_delay)
            begin
                sh_least       = k;
                sh_least_delay = sh_delay[k];
            end
        end
    endfunction

    function automatic void drop_slot(int pos);
        for (int k = pos; k + 1 < sh_count; k++)
        begin
            sh_delay[k]  = sh_delay[k+1];
            sh_period[k] = sh_period[k+1];
            sh_pend[k]   = sh_pend[k+1];
            sh_id[k]     = sh_id[k+1];
        end
        sh_count--;
        find_least();
    endfunction

    // Apply one operation to the shadow table and return the result it must give.
    function automatic result_t schedule_op(logic [1:0] op, logic [31:0] sdel,
                                            logic [31:0] per, logic [4:0] pos);
        result_t r;
        int      s;
        r = '0;
        case (op)
            OP_ADD:
            begin
                if (sh_count >= NTASK)
                    r.status = ST_FULL;
                else
                begin
                    sh_delay[sh_count]  = sdel;
                    sh_period[sh_count] = per;
                    sh_pend[sh_count]   = '0;
                    sh_id[sh_count]     = sh_count[4:0];
                    r.id                = sh_count[4:0];
                    sh_count++;
                    find_least();
                end
            end
            OP_DELETE:
            begin
                if (int'(pos) >= sh_count)
                    r.status = ST_BAD_SLOT;
                else
                    drop_slot(int'(pos));
            end
            OP_TICK:
            begin
                if (sh_count > 0)
                begin
                    s = sh_least;
                    if (sh_delay[s] > 0)
                        sh_delay[s]--;
                    else
                    begin
                        sh_delay[s] = sh_period[s];
                        if (sh_pend[s] != PEND_MAX)
                            sh_pend[s]++;
                    end
                end
            end
            default:
            begin
                if (sh_count > 0 && sh_pend[sh_least] > 0)
                begin
                    s = sh_least;
                    for (int k = 0; k < sh_count; k++)
                        if (k != s)
                            sh_delay[k] -= sh_least_delay;
                    find_least();
                    r.run = 1'b1;
                    r.id  = sh_id[s];
                    sh_pend[s]--;
                    if (sh_period[s] == 0)
                        drop_slot(s);
                end
            end
        endcase
        r.held = sh_count[5:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one operation; the expectation is logged when the transfer happens.
    // The valid flag stays up between operations unless an idle burst is drawn.
    task automatic send_op(logic [1:0] op, logic [31:0] sdel = '0,
                           logic [31:0] per = '0, logic [4:0] pos = '0);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, pos, per, sdel};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(schedule_op(op, sdel, per, pos));
        @(negedge clk);
    endtask

    // Random 32-bit value biased toward small delays so ticks reach zero.
    function automatic logic [31:0] rand_delay();
        case ($urandom_range(0, 7))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1:       return $urandom;
            default: return $urandom_range(0, 4);
        endcase
    endfunction

    // Output side: random stalls on m_tready, sampled at the rising edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (idle_enable && $urandom_range(0, 4) == 0)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // Result checker: compares each output transfer with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected", $realtime);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser[1:0] !== want.status)
                    report_mismatch("status", int'(m_tuser[1:0]), int'(want.status));
                if (m_tuser[2] !== want.run)
                    report_mismatch("run_valid", int'(m_tuser[2]), int'(want.run));
                if (m_tdata[4:0] !== want.id)
                    report_mismatch("task_id", int'(m_tdata[4:0]), int'(want.id));
                if (m_tdata[10:5] !== want.held)
                    report_mismatch("tasks_held", int'(m_tdata[10:5]), int'(want.held));
            end
        end
    end

    // Watchdog: ends the run when nothing has been accepted for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Empty table, extreme values, bad slots and one-shot runs.
    task automatic test_directed();
        send_op(OP_TICK);
        send_op(OP_DISPATCH);
        send_op(OP_DELETE, '0, '0, 5'd0);
        send_op(OP_ADD, 32'd0, 32'd0);
        send_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_ADD, 32'd1, 32'd2);
        send_op(OP_DISPATCH);
        send_op(OP_TICK);
        send_op(OP_DISPATCH);
        send_op(OP_DISPATCH);
        send_op(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_op(OP_DELETE, '0, '0, 5'd0);
        send_op(OP_TICK);
        send_op(OP_TICK);
        send_op(OP_DISPATCH);
    endtask

    // Fill the table to overflow, empty it, then saturate a pending count and run it once.
    task automatic test_full_table();
        while (sh_count < NTASK)
            send_op(OP_ADD, $urandom_range(5, 9), $urandom_range(0, 3));
        send_op(OP_ADD, 32'd1, 32'd1);
        send_op(OP_DELETE, '0, '0, 5'd31);
        while (sh_count > 0)
            send_op(OP_DELETE, '0, '0, 5'd0);
        send_op(OP_ADD, 32'd0, 32'd0);
        repeat (260) send_op(OP_TICK);
        send_op(OP_DISPATCH);
        send_op(OP_DELETE, '0, '0, 5'd0);
    endtask

    // Random mix, weighted so ticks lead to runs and the table stays populated.
    task automatic test_random(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25 && sh_count < NTASK)
                send_op(OP_ADD, rand_delay(), $urandom_range(0, 1) ? rand_delay() : '0,
                        5'($urandom));
            else if (pick < 35)
                send_op(OP_DELETE, $urandom, $urandom,
                        5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                        : $urandom_range(0, sh_count > 0 ? sh_count - 1 : 0)));
            else if (pick < 70)
                send_op(OP_TICK, $urandom, $urandom, 5'($urandom));
            else
                send_op(OP_DISPATCH, $urandom, $urandom, 5'($urandom));
        end
    endtask

    initial
    begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_ADD;
        m_tready    = 1'b0;
        rst_n       = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        idle_enable = 1'b1;
        sh_count    = 0;
        sh_least    = 0;
        sh_least_delay = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_table();
        test_random(380);
        idle_enable = 1'b0;
        test_random(130);
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3 * NTASK) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
